// File: sv/rmq_pkg.sv
`timescale 1ns / 1ps
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int IN_W      = 16;
   localparam int OUT_W     = 16;

   // t is one plus or minus three matrix entries; each v component is t or a sum or difference of two
   localparam int V_W       = ((FRAC_BITS + 2 > IN_W) ? FRAC_BITS + 2 : IN_W) + 2;
   localparam int T_W       = V_W - 1;
   localparam int N_W       = T_W + FRAC_BITS;
   localparam int SQ_STEPS  = (N_W + 1) / 2;
   localparam int S_W       = SQ_STEPS;
   localparam int N_PAD     = 2 * SQ_STEPS;
   localparam int R_W       = S_W + 3;

   localparam int MAG_W     = V_W;
   localparam int DIVD_W    = MAG_W + FRAC_BITS + 1;
   localparam int D_W       = S_W + 1;
   localparam int QB        = OUT_W - 1;
   localparam int R2_W      = D_W + 1;
   localparam int CMP_W     = (DIVD_W > D_W + QB) ? DIVD_W + 1 : D_W + QB + 1;

   localparam longint LIM_VAL = ((64'd1 << FRAC_BITS) > 64'd32767) ? 64'd32767
                                                                 : (64'd1 << FRAC_BITS);
   localparam logic [QB-1:0] LIM_Q = QB'(LIM_VAL);

   typedef struct packed {
      logic [T_W-1:0]          t;
      logic [3:0][V_W-1:0]     v;
   } front_type;

   typedef struct packed {
      logic [N_PAD-1:0]        n;
      logic [S_W-1:0]          root;
      logic [R_W-1:0]          rem;
      logic [3:0][V_W-1:0]     v;
   } sqrt_type;

   typedef struct packed {
      logic [D_W-1:0]          den;
      logic [3:0]              neg;
      logic [3:0]              ovf;
      logic [3:0][DIVD_W-1:0]  num;
      logic [3:0][R2_W-1:0]    rem;
      logic [3:0][QB-1:0]      quo;
   } div_type;

   typedef logic [3:0][OUT_W-1:0] quat_type;

endpackage

// File: sv/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Converts a 3x3 rotation matrix (Q1.14) to a unit quaternion (x, y, z, w) in Q1.14,
// saturated to +-1.0. One matrix is taken every cycle when the result side does not stall:
// one register stage picks the branch and forms t and the vector, sixteen stages compute the
// integer square root one bit each, and sixteen more set up and run four restoring dividers
// one quotient bit per stage, the last register saturating and applying the sign.
module rotation_matrix_to_quaternion (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [15:0]   req_r00,
   input  logic [15:0]   req_r01,
   input  logic [15:0]   req_r02,
   input  logic [15:0]   req_r10,
   input  logic [15:0]   req_r11,
   input  logic [15:0]   req_r12,
   input  logic [15:0]   req_r20,
   input  logic [15:0]   req_r21,
   input  logic [15:0]   req_r22,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [15:0]   rsp_quat_x,
   output logic [15:0]   rsp_quat_y,
   output logic [15:0]   rsp_quat_z,
   output logic [15:0]   rsp_quat_w
);
   import rmq_pkg::*;

   logic [8:0][15:0]  m;
   logic              fr_valid, fr_ready;
   front_type         fr_data;
   logic              sq_valid, sq_ready;
   sqrt_type          sq_data;
   quat_type          q;

   assign m = {req_r22, req_r21, req_r20, req_r12, req_r11, req_r10,
               req_r02, req_r01, req_r00};

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_m      (m),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   rmq_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_data  (sq_data)
   );

   rmq_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_data   (sq_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (q)
   );

   assign rsp_quat_x = q[0];
   assign rsp_quat_y = q[1];
   assign rsp_quat_z = q[2];
   assign rsp_quat_w = q[3];

   a_reset_empty : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_t_positive : assert property (@(posedge clock) disable iff (reset)
      fr_valid |-> fr_data.t != '0)
      else $error("t not clamped");

   a_root_nonzero : assert property (@(posedge clock) disable iff (reset)
      sq_valid |-> sq_data.root != '0)
      else $error("square root is zero");

   a_sat_x : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_quat_x) <= $signed(17'(LIM_VAL)) &&
                     $signed(rsp_quat_x) >= -$signed(17'(LIM_VAL))))
      else $error("quat_x beyond saturation bound");

endmodule

// File: sv/rmq_front.sv
`timescale 1ns / 1ps
module rmq_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [8:0][15:0]        in_m,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rmq_pkg::front_type      out_data
);
   import rmq_pkg::*;

   localparam logic signed [V_W-1:0] ONE_V = V_W'(64'd1 << FRAC_BITS);

   logic                    vld_ff;
   front_type               dat_ff;
   front_type               dat_in;
   logic signed [V_W-1:0]   m [9];
   logic signed [V_W-1:0]   t, vx, vy, vz, vw;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         m[i] = V_W'($signed(in_m[i]));
      end
      if (m[8] < 0) begin
         if (m[0] > m[4]) begin
            t  = ONE_V + m[0] - m[4] - m[8];
            vx = t; vy = m[3] + m[1]; vz = m[2] + m[6]; vw = m[7] - m[5];
         end else begin
            t  = ONE_V - m[0] + m[4] - m[8];
            vx = m[3] + m[1]; vy = t; vz = m[7] + m[5]; vw = m[2] - m[6];
         end
      end else begin
         if (m[0] < -m[4]) begin
            t  = ONE_V - m[0] - m[4] + m[8];
            vx = m[2] + m[6]; vy = m[7] + m[5]; vz = t; vw = m[3] - m[1];
         end else begin
            t  = ONE_V + m[0] + m[4] + m[8];
            vx = m[7] - m[5]; vy = m[2] - m[6]; vz = m[3] - m[1]; vw = t;
         end
      end
      // clamp non-positive t to one LSB
      dat_in.t = (t < 1) ? T_W'(1) : T_W'(t);
      dat_in.v = {vw, vz, vy, vx};
   end

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_data  = dat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         dat_ff <= dat_in;
      end
   end

endmodule

// File: sv/rmq_isqrt.sv
`timescale 1ns / 1ps
module rmq_isqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rmq_pkg::front_type      in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rmq_pkg::sqrt_type       out_data
);
   import rmq_pkg::*;

   localparam int DEP = SQ_STEPS;

   logic [DEP-1:0]   vld_ff;
   sqrt_type         stg_ff [DEP];
   sqrt_type         stg_in [DEP];
   sqrt_type         init;
   logic [DEP:0]     rdy;

   // one result bit per stage: bring down two bits, try root*4+1
   function automatic sqrt_type sq_step(sqrt_type a);
      sqrt_type         b;
      logic [R_W-1:0]   rem2;
      logic [R_W-1:0]   trial;
      b     = a;
      rem2  = {a.rem[R_W-3:0], a.n[N_PAD-1 -: 2]};
      trial = R_W'({a.root, 2'b01});
      b.n   = a.n << 2;
      if (rem2 >= trial) begin
         b.rem  = rem2 - trial;
         b.root = {a.root[S_W-2:0], 1'b1};
      end else begin
         b.rem  = rem2;
         b.root = {a.root[S_W-2:0], 1'b0};
      end
      return b;
   endfunction

   always_comb begin
      init      = '0;
      init.n    = N_PAD'(in_data.t) << FRAC_BITS;
      init.v    = in_data.v;
      stg_in[0] = sq_step(init);
      for (int i = 1; i < DEP; i++) begin
         stg_in[i] = sq_step(stg_ff[i-1]);
      end
   end

   always_comb begin
      rdy[DEP] = out_ready;
      for (int i = DEP - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[DEP-1];
   assign out_data  = stg_ff[DEP-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int i = 1; i < DEP; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEP; i++) begin
         if (rdy[i]) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

endmodule

// File: sv/rmq_divide.sv
`timescale 1ns / 1ps
module rmq_divide (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rmq_pkg::sqrt_type       in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rmq_pkg::quat_type       out_data
);
   import rmq_pkg::*;

   // stage 0 sets up, stages 1..QB each make one quotient bit per lane
   localparam int DEP = QB + 1;

   logic [DEP-1:0]       vld_ff;
   div_type              stg_ff [DEP];
   div_type              stg_in [DEP];
   logic [DEP:0]         rdy;
   logic                 out_vld_ff;
   quat_type             out_ff;
   quat_type             out_in;
   logic signed [V_W-1:0] vs;
   logic [MAG_W-1:0]     mag;
   logic [R2_W-1:0]      rem2;
   logic [QB-1:0]        qv;

   always_comb begin
      stg_in[0]     = '0;
      stg_in[0].den = {in_data.root, 1'b0};
      for (int l = 0; l < 4; l++) begin
         vs  = $signed(in_data.v[l]);
         mag = (vs < 0) ? MAG_W'(-vs) : MAG_W'(vs);
         stg_in[0].neg[l] = vs < 0;
         stg_in[0].num[l] = (DIVD_W'(mag) << FRAC_BITS) + DIVD_W'(in_data.root);
         stg_in[0].ovf[l] = CMP_W'(stg_in[0].num[l]) >= (CMP_W'(stg_in[0].den) << QB);
         stg_in[0].rem[l] = R2_W'(stg_in[0].num[l] >> QB);
      end
      for (int j = 1; j < DEP; j++) begin
         stg_in[j] = stg_ff[j-1];
         for (int l = 0; l < 4; l++) begin
            rem2 = {stg_ff[j-1].rem[l][R2_W-2:0], stg_ff[j-1].num[l][QB-j]};
            if (rem2 >= R2_W'(stg_ff[j-1].den)) begin
               stg_in[j].rem[l] = rem2 - R2_W'(stg_ff[j-1].den);
               stg_in[j].quo[l] = {stg_ff[j-1].quo[l][QB-2:0], 1'b1};
            end else begin
               stg_in[j].rem[l] = rem2;
               stg_in[j].quo[l] = {stg_ff[j-1].quo[l][QB-2:0], 1'b0};
            end
         end
      end
   end

   // saturate, then restore the sign
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (stg_ff[DEP-1].ovf[l] || stg_ff[DEP-1].quo[l] > LIM_Q) begin
            qv = LIM_Q;
         end else begin
            qv = stg_ff[DEP-1].quo[l];
         end
         out_in[l] = stg_ff[DEP-1].neg[l] ? -OUT_W'(qv) : OUT_W'(qv);
      end
   end

   always_comb begin
      rdy[DEP] = !out_vld_ff || out_ready;
      for (int i = DEP - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int i = 1; i < DEP; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
         if (rdy[DEP]) begin
            out_vld_ff <= vld_ff[DEP-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEP; i++) begin
         if (rdy[i]) begin
            stg_ff[i] <= stg_in[i];
         end
      end
      if (rdy[DEP]) begin
         out_ff <= out_in;
      end
   end

endmodule

// File: test/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion;
   import rmq_pkg::*;

   localparam int ONE_Q       = 1 << FRAC_BITS;
   localparam int STALL_LIMIT = 4000;
   localparam int N_RANDOM    = 400;
   localparam int N_TABLE     = 20;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic [15:0] w;
   } quat_word_type;

   typedef struct {
      logic [8:0][15:0] m;
      bit               known;
      quat_word_type    q;
   } mat_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_r00 = '0, req_r01 = '0, req_r02 = '0;
   logic [15:0] req_r10 = '0, req_r11 = '0, req_r12 = '0;
   logic [15:0] req_r20 = '0, req_r21 = '0, req_r22 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;

   quat_word_type quat_queue[$];
   int            fail_count = 0;
   int            words_in = 0;
   int            words_out = 0;
   int            idle_cycles = 0;
   int            src_idle_pct = 0;
   int            snk_stall_pct = 0;
   mat_row_type   dir_rows[N_TABLE];

   rotation_matrix_to_quaternion dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] scale_component(longint v, longint unsigned s);
      longint unsigned mag = (v < 0) ? -v : v;
      longint unsigned q = ((mag << FRAC_BITS) + s) / (2 * s);
      longint unsigned lim = (ONE_Q > 32767) ? 32767 : ONE_Q;
      longint r;
      if (q > lim) q = lim;
      r = (v < 0) ? -longint'(q) : longint'(q);
      return r[15:0];
   endfunction

   function automatic quat_word_type matrix_to_quat(logic [8:0][15:0] m);
      longint e[9];
      longint t, vx, vy, vz, vw;
      longint unsigned s;
      quat_word_type q;
      for (int i = 0; i < 9; i++) e[i] = longint'($signed(m[i]));
      // e: r00 r01 r02 r10 r11 r12 r20 r21 r22
      if (e[8] < 0) begin
         if (e[0] > e[4]) begin
            t = ONE_Q + e[0] - e[4] - e[8];
            vx = t; vy = e[3] + e[1]; vz = e[2] + e[6]; vw = e[7] - e[5];
         end else begin
            t = ONE_Q - e[0] + e[4] - e[8];
            vx = e[3] + e[1]; vy = t; vz = e[7] + e[5]; vw = e[2] - e[6];
         end
      end else begin
         if (e[0] < -e[4]) begin
            t = ONE_Q - e[0] - e[4] + e[8];
            vx = e[2] + e[6]; vy = e[7] + e[5]; vz = t; vw = e[3] - e[1];
         end else begin
            t = ONE_Q + e[0] + e[4] + e[8];
            vx = e[7] - e[5]; vy = e[2] - e[6]; vz = e[3] - e[1]; vw = t;
         end
      end
      if (t < 1) t = 1;
      s = root_floor(longint'(t) << FRAC_BITS);
      if (s == 0) s = 1;
      q.x = scale_component(vx, s);
      q.y = scale_component(vy, s);
      q.z = scale_component(vz, s);
      q.w = scale_component(vw, s);
      return q;
   endfunction

   function automatic logic [15:0] rand_entry();
      int k = $urandom_range(0, 9);
      if (k == 0) return 16'($urandom);
      if (k == 1) return (k[0] ^ $urandom_range(0, 1)) ? 16'h4000 : 16'hC000;
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   // random rotation built from a normalized random quaternion
   function automatic logic [8:0][15:0] rand_rotation();
      real a, b, c, d, n;
      real r[9];
      logic [8:0][15:0] m;
      a = real'($urandom_range(0, 2000)) - 1000.0;
      b = real'($urandom_range(0, 2000)) - 1000.0;
      c = real'($urandom_range(0, 2000)) - 1000.0;
      d = real'($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a*a + b*b + c*c + d*d);
      if (n < 1.0) begin
         a = 1.0; n = 1.0;
      end
      a /= n; b /= n; c /= n; d /= n;
      r[0] = 1 - 2*(c*c + d*d); r[1] = 2*(b*c - a*d);     r[2] = 2*(b*d + a*c);
      r[3] = 2*(b*c + a*d);     r[4] = 1 - 2*(b*b + d*d); r[5] = 2*(c*d - a*b);
      r[6] = 2*(b*d - a*c);     r[7] = 2*(c*d + a*b);     r[8] = 1 - 2*(b*b + c*c);
      for (int i = 0; i < 9; i++) m[i] = 16'($rtoi(r[i] * ONE_Q));
      return m;
   endfunction

   function automatic logic [8:0][15:0] mat_of(int d0, int d1, int d2, int o);
      logic [8:0][15:0] m;
      m[0] = 16'(d0); m[4] = 16'(d1); m[8] = 16'(d2);
      m[1] = 16'(o); m[2] = 16'(o); m[3] = 16'(o);
      m[5] = 16'(o); m[6] = 16'(o); m[7] = 16'(o);
      return m;
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_matrix(logic [8:0][15:0] m);
      while ($urandom_range(1, 100) <= src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_r22, req_r21, req_r20, req_r12, req_r11, req_r10, req_r02, req_r01, req_r00}
         <= m;
      quat_queue.push_back(matrix_to_quat(m));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_in++;
      @(negedge clock);
   endtask

   function automatic void report_field(string nm, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch %s expected %0d actual %0d", $time, nm,
                  $signed(exp_v), $signed(act_v));
         fail_count++;
      end
   endfunction

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      quat_word_type exp_q;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            words_out++;
            if (quat_queue.size() == 0) begin
               $display("%0t: unexpected word %h %h %h %h", $time,
                        rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w);
               fail_count++;
            end else begin
               exp_q = quat_queue.pop_front();
               report_field("quat_x", exp_q.x, rsp_quat_x);
               report_field("quat_y", exp_q.y, rsp_quat_y);
               report_field("quat_z", exp_q.z, rsp_quat_z);
               report_field("quat_w", exp_q.w, rsp_quat_w);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d words pending", $time, quat_queue.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(1, 100) > snk_stall_pct);
   end

   initial begin
      int n_rot;
      // identity and its half-turns: expected results are plain
      dir_rows[0] = '{mat_of(ONE_Q, ONE_Q, ONE_Q, 0), 1, '{0, 0, 0, ONE_Q}};
      dir_rows[1] = '{mat_of(ONE_Q, -ONE_Q, -ONE_Q, 0), 1, '{ONE_Q, 0, 0, 0}};
      dir_rows[2] = '{mat_of(-ONE_Q, ONE_Q, -ONE_Q, 0), 1, '{0, ONE_Q, 0, 0}};
      dir_rows[3] = '{mat_of(-ONE_Q, -ONE_Q, ONE_Q, 0), 1, '{0, 0, ONE_Q, 0}};
      // matrices that are not rotations
      dir_rows[4] = '{mat_of(-ONE_Q, 0, ONE_Q, ONE_Q), 0, '{0, 0, 0, 0}};
      dir_rows[5] = '{mat_of(-ONE_Q, -ONE_Q, -ONE_Q, 0), 0, '{0, 0, 0, 0}};
      dir_rows[6] = '{mat_of(-ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q), 0, '{0, 0, 0, 0}};
      // out-of-range and extreme patterns
      dir_rows[7] = '{mat_of(32767, 32767, 32767, 32767), 0, '{0, 0, 0, 0}};
      dir_rows[8] = '{mat_of(-32768, -32768, -32768, -32768), 0, '{0, 0, 0, 0}};
      dir_rows[9] = '{mat_of(-32768, 32767, -32768, 32767), 0, '{0, 0, 0, 0}};
      dir_rows[10] = '{mat_of(0, 0, 0, 0), 0, '{0, 0, 0, 0}};
      dir_rows[11] = '{{9{16'hFFFF}}, 0, '{0, 0, 0, 0}};
      dir_rows[12] = '{{9{16'h5555}}, 0, '{0, 0, 0, 0}};
      dir_rows[13] = '{{9{16'hAAAA}}, 0, '{0, 0, 0, 0}};
      // branch boundaries: r00 equal to r11, r00 equal to -r11, r22 zero
      dir_rows[14] = '{mat_of(-100, -100, -1, 77), 0, '{0, 0, 0, 0}};
      dir_rows[15] = '{mat_of(200, -200, 0, -33), 0, '{0, 0, 0, 0}};
      dir_rows[16] = '{mat_of(201, -200, 0, 1000), 0, '{0, 0, 0, 0}};
      for (int i = 17; i < N_TABLE; i++) dir_rows[i] = '{rand_rotation(), 0, '{0, 0, 0, 0}};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].known && matrix_to_quat(dir_rows[i].m) !== dir_rows[i].q) begin
            $display("%0t: table row %0d expected %h actual prediction %h", $time, i,
                     dir_rows[i].q, matrix_to_quat(dir_rows[i].m));
            fail_count++;
         end
         send_matrix(dir_rows[i].m);
      end

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
            default: begin src_idle_pct = 24; snk_stall_pct = 24; end
         endcase
         n_rot = N_RANDOM / 4;
         for (int i = 0; i < n_rot; i++) begin
            if ($urandom_range(0, 3) != 0) send_matrix(rand_rotation());
            else send_matrix({rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                              rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                              rand_entry()});
         end
      end
      req_valid <= 1'b0;

      snk_stall_pct = 0;
      while (quat_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d matrices (table rows, rotations, raw patterns), got %0d quaternions",
               words_in, words_out);
      $display("under four idle/stall mixes");
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
